// ===== hdl/mst_fragment_edge_protocol_macros.svh =====
// assertion helpers for the fragment edge protocol block
`ifndef MST_FRAGMENT_EDGE_PROTOCOL_MACROS_SVH
`define MST_FRAGMENT_EDGE_PROTOCOL_MACROS_SVH
`ifndef SYNTHESIS
`define MFE_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MFE_ASSERT_IMPL(label, clk, rst_n, prop)
`define MFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/mfe_pkg.sv =====
package mfe_pkg;
  localparam int MaxEdges = 16;
  localparam int HistDepth = 8;
  localparam int MaxResults = 16;
  localparam int EIdxW = $clog2(MaxEdges);
  localparam int ECntW = $clog2(MaxEdges + 1);
  localparam int HIdxW = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int HCntW = $clog2(HistDepth + 1);
  localparam int RCntW = $clog2(MaxResults + 1);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_MSG   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic MSG_CONNECT  = 1'b0;
  localparam logic MSG_INITIATE = 1'b1;

  localparam logic [1:0] KIND_INITIATE = 2'd0;
  localparam logic [1:0] KIND_DUP      = 2'd1;
  localparam logic [1:0] KIND_START    = 2'd2;
  localparam logic [1:0] KIND_FAIL     = 2'd3;

  typedef logic [4:0] child_cnt_t;
endpackage

// ===== hdl/mst_fragment_edge_protocol.sv =====
// fragment edge protocol node
// input channel: in_* fields, taken on a clock edge with start high and busy low.
// result channel: out_* fields with out_valid for one cycle each; out_last marks the
// final result of an item. the receiver cannot stall, results are never held.
// op load: takes the edge into the table (no result), otherwise one fail beat.
// op start: scans the edge table one entry a cycle.
// op message: scans the sender history one entry a cycle (a duplicate gives one DUP
// beat), then the edge table one entry a cycle, emitting one INITIATE beat per
// matching branch edge; each beat is held until the next is found or the scan ends.
// one item at a time: busy falls on the edge that drives the last beat of an item,
// so the next item can be taken while that beat is on the ports.
// the rate is set by the single table scan sequencer and one compare per cycle.
// reset (synchronous, rst_n low) clears the edge count, branch marks, history
// fill and fragment state; the address, weight and history tables hold garbage
// until written and are never read before.
module mst_fragment_edge_protocol
  import mfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_addr,
  input  logic [31:0] in_weight,
  input  logic [7:0]  in_seqno,
  input  logic        in_msg_type,
  input  logic [7:0]  in_msg_level,
  input  logic [31:0] in_msg_name,
  input  logic [1:0]  in_msg_state,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [15:0] out_dest_addr,
  output logic [31:0] out_frag_name_out,
  output logic [7:0]  out_frag_level_out,
  output logic [1:0]  out_node_state_out,
  output logic        out_last
);
`include "mst_fragment_edge_protocol_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_HIST = 3'd2;
  localparam logic [2:0] S_CONN = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state_r;
  logic [15:0] e_addr_r [MaxEdges];
  logic [31:0] e_wt_r [MaxEdges];
  logic [MaxEdges-1:0] e_br_r;
  logic [ECntW-1:0] e_cnt_r;
  logic [15:0] h_addr_r [HistDepth];
  logic [7:0] h_seq_r [HistDepth];
  logic [HCntW-1:0] h_fill_r;
  logic [HIdxW-1:0] h_old_r;
  logic [31:0] f_name_r;
  logic [7:0] f_level_r;
  logic [1:0] mode_r;
  logic [15:0] parent_r;
  child_cnt_t child_r;
  logic core_r;
  logic [15:0] least_r;

  // item latch
  logic [15:0] a_r;
  logic [7:0] seq_r, lvl_r;
  logic typ_r;
  logic [31:0] name_r;
  logic [1:0] st_r;

  logic [ECntW-1:0] ei_r;
  logic [HCntW-1:0] hi_r;
  logic [RCntW-1:0] n_r;
  // held pending beat, emitted when the next one is known or at the end
  logic pend_r;
  logic [15:0] pdest_r;

  logic ov_r, ol_r;
  logic [1:0] ok_r, ost_r;
  logic [15:0] od_r;
  logic [31:0] on_r;
  logic [7:0] olv_r;

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_dest_addr = od_r;
  assign out_frag_name_out = on_r;
  assign out_frag_level_out = olv_r;
  assign out_node_state_out = ost_r;
  assign out_last = ol_r;

  wire [EIdxW-1:0] ei = ei_r[EIdxW-1:0];
  wire [HIdxW-1:0] hi = hi_r[HIdxW-1:0];
  wire e_more = (ei_r < e_cnt_r);
  wire h_more = (hi_r < h_fill_r);

  function automatic child_cnt_t inc_c(child_cnt_t c);
    return (c == 5'd31) ? c : c + 5'd1;
  endfunction

  always_ff @(posedge clk) begin
    ov_r <= 1'b0;
    ol_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      e_br_r <= '0;
      e_cnt_r <= '0;
      h_fill_r <= '0;
      h_old_r <= '0;
      f_name_r <= '0;
      f_level_r <= '0;
      mode_r <= '0;
      parent_r <= '0;
      child_r <= '0;
      core_r <= 1'b0;
      least_r <= '0;
      pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            a_r <= in_addr;
            seq_r <= in_seqno;
            typ_r <= in_msg_type;
            lvl_r <= in_msg_level;
            name_r <= in_msg_name;
            st_r <= in_msg_state;
            ei_r <= '0;
            hi_r <= '0;
            n_r <= '0;
            pend_r <= 1'b0;
            case (in_op)
              OP_LOAD: begin
                if (e_cnt_r >= ECntW'(MaxEdges)) begin
                  ov_r <= 1'b1; ol_r <= 1'b1; ok_r <= KIND_FAIL;
                  od_r <= '0; on_r <= '0; olv_r <= '0; ost_r <= '0;
                end else begin
                  e_addr_r[e_cnt_r[EIdxW-1:0]] <= in_addr;
                  e_wt_r[e_cnt_r[EIdxW-1:0]] <= in_weight;
                  e_br_r[e_cnt_r[EIdxW-1:0]] <= 1'b0;
                  e_cnt_r <= e_cnt_r + 1'b1;
                end
              end
              OP_START: state_r <= S_START;
              OP_MSG: state_r <= S_HIST;
              default: ;
            endcase
          end
        end
        S_START: begin
          if (!e_more) begin
            ov_r <= 1'b1; ol_r <= 1'b1; ok_r <= KIND_FAIL;
            od_r <= '0; on_r <= '0; olv_r <= '0; ost_r <= '0;
            state_r <= S_IDLE;
          end else if (!e_br_r[ei]) begin
            e_br_r[ei] <= 1'b1;
            least_r <= e_addr_r[ei];
            f_name_r <= '0; f_level_r <= '0; core_r <= 1'b0;
            ov_r <= 1'b1; ol_r <= 1'b1; ok_r <= KIND_START;
            od_r <= e_addr_r[ei]; on_r <= '0; olv_r <= '0; ost_r <= '0;
            state_r <= S_IDLE;
          end else begin
            ei_r <= ei_r + 1'b1;
          end
        end
        S_HIST: begin
          if (h_more && h_addr_r[hi] == a_r) begin
            if (h_seq_r[hi] == seq_r) begin
              ov_r <= 1'b1; ol_r <= 1'b1; ok_r <= KIND_DUP;
              od_r <= a_r; on_r <= '0; olv_r <= '0; ost_r <= '0;
              state_r <= S_IDLE;
            end else begin
              h_seq_r[hi] <= seq_r;
              state_r <= (typ_r == MSG_CONNECT) ? S_CONN : S_INIT;
            end
          end else if (h_more) begin
            hi_r <= hi_r + 1'b1;
          end else begin
            if (h_fill_r < HCntW'(HistDepth)) begin
              h_addr_r[h_fill_r[HIdxW-1:0]] <= a_r;
              h_seq_r[h_fill_r[HIdxW-1:0]] <= seq_r;
              h_fill_r <= h_fill_r + 1'b1;
            end else begin
              h_addr_r[h_old_r] <= a_r;
              h_seq_r[h_old_r] <= seq_r;
              h_old_r <= (h_old_r == HIdxW'(HistDepth - 1)) ? '0 : h_old_r + 1'b1;
            end
            state_r <= (typ_r == MSG_CONNECT) ? S_CONN : S_INIT;
          end
          if (typ_r == MSG_INITIATE && !(h_more && h_addr_r[hi] == a_r
              && h_seq_r[hi] == seq_r) && (!h_more || h_addr_r[hi] == a_r)) begin
            f_name_r <= name_r; f_level_r <= lvl_r;
            mode_r <= st_r; parent_r <= a_r;
          end
        end
        S_CONN: begin
          if (lvl_r != f_level_r || !e_more) begin
            state_r <= S_IDLE;
          end else if (e_addr_r[ei] == a_r) begin
            if (e_br_r[ei]) begin
              child_r <= inc_c(child_r);
              core_r <= 1'b1;
              ov_r <= 1'b1; ol_r <= 1'b1; ok_r <= KIND_INITIATE;
              od_r <= a_r; on_r <= e_wt_r[ei];
              olv_r <= (f_level_r == 8'd255) ? 8'd255 : f_level_r + 8'd1;
              ost_r <= '0;
            end
            state_r <= S_IDLE;
          end else begin
            ei_r <= ei_r + 1'b1;
          end
        end
        S_INIT: begin
          if (!e_more || n_r >= RCntW'(MaxResults)) begin
            state_r <= S_FLUSH;
          end else begin
            if (e_br_r[ei] && e_addr_r[ei] != a_r) begin
              child_r <= inc_c(child_r);
              n_r <= n_r + 1'b1;
              pend_r <= 1'b1;
              pdest_r <= e_addr_r[ei];
              if (pend_r) begin
                ov_r <= 1'b1; ok_r <= KIND_INITIATE; od_r <= pdest_r;
                on_r <= name_r; olv_r <= lvl_r; ost_r <= st_r;
              end
            end
            ei_r <= ei_r + 1'b1;
          end
        end
        S_FLUSH: begin
          if (pend_r) begin
            ov_r <= 1'b1; ol_r <= 1'b1; ok_r <= KIND_INITIATE; od_r <= pdest_r;
            on_r <= name_r; olv_r <= lvl_r; ost_r <= st_r;
          end
          pend_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MFE_ASSERT_IMPL(a_last_valid, clk, rst_n, out_last |-> out_valid)
  `MFE_ASSERT_IMPL(a_cnt_range, clk, rst_n, e_cnt_r <= ECntW'(MaxEdges))
  `MFE_ASSERT_NEXT(a_take, clk, rst_n, (start && !busy && (in_op == OP_START)), busy)
endmodule
